// ===== rtl/core/irr_pkg.sv =====
`default_nettype none

package irr_pkg;

   // number of local interrupts served by one redistributor
   localparam int unsigned LOCAL_IRQS = 32;

   // payload widths
   localparam int unsigned OFFSET_W = 17;
   localparam int unsigned SIZE_W   = 2;
   localparam int unsigned DATA_W   = 64;
   localparam int unsigned WORD_W   = 32;

   // request beat: offset, access size and write data packed, padded to bytes
   localparam int unsigned REQ_FIELDS_W = OFFSET_W + SIZE_W + DATA_W;
   localparam int unsigned REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned REQ_PAD_W    = REQ_TDATA_W - REQ_FIELDS_W;

   // response beat: read data only
   localparam int unsigned RSP_TDATA_W = DATA_W;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_AFFINITY      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TYPE_FLAGS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARCH_REVISION = 2'd2;

   localparam logic [3:0] ARCH_REVISION_RST = 4'd3;

   // command and access size codes
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_BYTE    = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_WORD    = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_DWORD   = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_INVALID = 2'd3;

   // register map, control frame then local interrupt frame
   localparam logic [OFFSET_W-1:0] R_CTRL  = 17'h00000;
   localparam logic [OFFSET_W-1:0] R_TYPER = 17'h00008;
   localparam logic [OFFSET_W-1:0] R_WAKER = 17'h00014;
   localparam logic [OFFSET_W-1:0] R_PROPB = 17'h00070;
   localparam logic [OFFSET_W-1:0] R_PENDB = 17'h00078;
   localparam logic [OFFSET_W-1:0] R_PIDR2 = 17'h0ffe8;
   localparam logic [OFFSET_W-1:0] R_GROUP = 17'h10080;
   localparam logic [OFFSET_W-1:0] R_SETEN = 17'h10100;
   localparam logic [OFFSET_W-1:0] R_CLREN = 17'h10180;
   localparam logic [OFFSET_W-1:0] R_SETPD = 17'h10200;
   localparam logic [OFFSET_W-1:0] R_CLRPD = 17'h10280;
   localparam logic [OFFSET_W-1:0] R_SETAC = 17'h10300;
   localparam logic [OFFSET_W-1:0] R_CLRAC = 17'h10380;
   localparam logic [OFFSET_W-1:0] R_PRIO  = 17'h10400;
   localparam logic [OFFSET_W-1:0] R_CFG0  = 17'h10c00;
   localparam logic [OFFSET_W-1:0] R_CFG1  = 17'h10c04;

   // implemented fields of the lpi table base registers
   localparam logic [DATA_W-1:0] PROP_MASK = 64'h000F_FFFF_FFFF_FF9F;
   localparam logic [DATA_W-1:0] PEND_MASK = 64'h000F_FFFF_FFFF_0F80;

   // priority storage: four byte-wide priorities to a word
   localparam int unsigned PRIO_WORDS  = LOCAL_IRQS / 4;
   localparam int unsigned PRIO_IDX_W  = $clog2(LOCAL_IRQS);
   localparam int unsigned PRIO_WIDX_W = $clog2(PRIO_WORDS);

   // trigger configuration: sixteen 2-bit fields to a word
   localparam int unsigned CFG_FIELDS = 16;

   typedef struct packed {
      logic [REQ_PAD_W-1:0] pad;
      logic [DATA_W-1:0]    write_data;
      logic [SIZE_W-1:0]    access_size;
      logic [OFFSET_W-1:0]  offset;
   } req_data_type;

endpackage

`default_nettype wire

// ===== rtl/core/interrupt_redistributor_regs_core.sv =====
`default_nettype none

// Register block of an interrupt redistributor for 32 local interrupts. Each request beat is one
// bus access (read or write) with a byte offset across the control frame (0x00000) and the local
// interrupt frame (0x10000), an access size and write data; each access returns exactly one
// response beat with the read data (zero for writes and errors) and a decode error flag. Accesses
// are taken one per cycle while responses are accepted: a beat lands in an input register, the
// decode and read-modify-write of the register file work on that register and the response is
// held in an output register, so the throughput is one access per cycle, set by that single
// decode-and-update path. A stalled response only stops the input register once it is also full.
// The csr port sets affinity, type flags and revision and must only be written while idle.
module interrupt_redistributor_regs_core (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // offset [16:0], access_size [18:17], write_data [82:19], zero pad [87:83]
   input  wire  [irr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // command [0]
   input  wire  [0:0]                       req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // read_data [63:0]
   output logic [irr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // decode_error [0]
   output logic [0:0]                       rsp_tuser,
   // configuration write port
   input  wire                              csr_we,
   input  wire  [irr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [irr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import irr_pkg::*;

   // handshake
   logic                   req_fire;
   logic                   out_free;
   logic                   advance;

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic                   in_cmd_ff, in_cmd_in;
   req_data_type           in_pay_ff, in_pay_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]      out_data_ff, out_data_in;
   logic                   out_err_ff, out_err_in;

   // configuration registers
   logic [WORD_W-1:0]      affinity_ff, affinity_in;
   logic [2:0]             type_flags_ff, type_flags_in;
   logic [3:0]             arch_rev_ff, arch_rev_in;

   // interrupt state
   logic [LOCAL_IRQS-1:0]  enable_bits_ff, enable_bits_in;
   logic [LOCAL_IRQS-1:0]  pending_bits_ff, pending_bits_in;
   logic [LOCAL_IRQS-1:0]  active_bits_ff, active_bits_in;
   logic [LOCAL_IRQS-1:0]  group_bits_ff, group_bits_in;
   logic [LOCAL_IRQS-1:0]  edge_bits_ff, edge_bits_in;   // upper bit of each trigger field
   logic [WORD_W-1:0]      prio_ff [PRIO_WORDS];
   logic [WORD_W-1:0]      prio_in [PRIO_WORDS];
   logic [1:0]             wake_ff, wake_in;             // bit0 processor-sleep, bit1 children-asleep
   logic                   lpi_enable_ff, lpi_enable_in;
   logic [DATA_W-1:0]      prop_base_ff, prop_base_in;
   logic [DATA_W-1:0]      pend_base_ff, pend_base_in;

   // decode of the access in the input register
   logic [OFFSET_W-1:0]    acc_off;
   logic [SIZE_W-1:0]      acc_size;
   logic [DATA_W-1:0]      acc_data;
   logic [WORD_W-1:0]      acc_d32;
   logic [OFFSET_W-1:0]    acc_base8;
   logic                   acc_wr;
   logic                   is_dword_reg;
   logic                   in_prio;
   logic [PRIO_WIDX_W-1:0] prio_widx;
   logic [4:0]             prio_bsel;
   logic [DATA_W-1:0]      typer_value;
   logic [DATA_W-1:0]      dword_cur;
   logic [DATA_W-1:0]      dword_new;
   logic [CFG_FIELDS-1:0]  cfg_sel;
   logic [DATA_W-1:0]      rd;
   logic                   err;

   // ---------------------------------------------------------------
   // beat flow: input register, then output register
   // ---------------------------------------------------------------
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_err_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_cmd_in   = in_cmd_ff;
      in_pay_in   = in_pay_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_cmd_in   = req_tuser[0];
         in_pay_in   = req_data_type'(req_tdata);
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // configuration writes, indexes beyond the list are dropped
   // ---------------------------------------------------------------
   always_comb begin
      affinity_in   = affinity_ff;
      type_flags_in = type_flags_ff;
      arch_rev_in   = arch_rev_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_AFFINITY:      affinity_in   = csr_wdata;
            CSR_TYPE_FLAGS:    type_flags_in = csr_wdata[2:0];
            CSR_ARCH_REVISION: arch_rev_in   = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // decode helpers
   // ---------------------------------------------------------------
   assign acc_off   = in_pay_ff.offset;
   assign acc_size  = in_pay_ff.access_size;
   assign acc_data  = in_pay_ff.write_data;
   assign acc_d32   = acc_data[WORD_W-1:0];
   assign acc_base8 = {acc_off[OFFSET_W-1:3], 3'b000};
   assign acc_wr    = advance && (in_cmd_ff == CMD_WRITE);

   // the three 64-bit registers share one 8-byte decode
   assign is_dword_reg = (acc_base8 == R_TYPER) || (acc_base8 == R_PROPB) ||
                         (acc_base8 == R_PENDB);

   // priorities occupy an aligned window of one byte per interrupt
   assign in_prio   = acc_off[OFFSET_W-1:PRIO_IDX_W] == R_PRIO[OFFSET_W-1:PRIO_IDX_W];
   assign prio_widx = acc_off[PRIO_IDX_W-1:2];
   assign prio_bsel = {acc_off[1:0], 3'b000};

   // affinity on top, flags in bits 1:0 and last-frame flag in bit 4
   assign typer_value = {affinity_ff, 27'd0, type_flags_ff[2], 2'b00, type_flags_ff[1:0]};

   assign dword_cur = (acc_base8 == R_TYPER) ? typer_value :
                      (acc_base8 == R_PROPB) ? prop_base_ff : pend_base_ff;

   // merge the written half or the whole doubleword into the current value
   always_comb begin
      if (acc_size == SIZE_DWORD) begin
         dword_new = acc_data;
      end else if (acc_off[2]) begin
         dword_new = {acc_d32, dword_cur[WORD_W-1:0]};
      end else begin
         dword_new = {dword_cur[DATA_W-1:WORD_W], acc_d32};
      end
   end

   assign cfg_sel = acc_off[2] ? edge_bits_ff[2*CFG_FIELDS-1:CFG_FIELDS]
                               : edge_bits_ff[CFG_FIELDS-1:0];

   // ---------------------------------------------------------------
   // register file: decode, read and read-modify-write in one pass
   // ---------------------------------------------------------------
   always_comb begin
      enable_bits_in  = enable_bits_ff;
      pending_bits_in = pending_bits_ff;
      active_bits_in  = active_bits_ff;
      group_bits_in   = group_bits_ff;
      edge_bits_in    = edge_bits_ff;
      prio_in         = prio_ff;
      wake_in         = wake_ff;
      lpi_enable_in   = lpi_enable_ff;
      prop_base_in    = prop_base_ff;
      pend_base_in    = pend_base_ff;
      rd              = '0;
      err             = 1'b0;

      if (acc_size == SIZE_INVALID) begin
         err = 1'b1;
      end else if (is_dword_reg) begin
         // doubleword at the base, or a word at either half
         if ((acc_size == SIZE_DWORD && acc_off[2:0] == 3'b000) ||
             (acc_size == SIZE_WORD && acc_off[1:0] == 2'b00)) begin
            if (acc_size == SIZE_DWORD) begin
               rd = dword_cur;
            end else if (acc_off[2]) begin
               rd = {{WORD_W{1'b0}}, dword_cur[DATA_W-1:WORD_W]};
            end else begin
               rd = {{WORD_W{1'b0}}, dword_cur[WORD_W-1:0]};
            end
            // table bases are frozen once lpis are enabled, type is read only
            if (acc_wr && !lpi_enable_ff) begin
               if (acc_base8 == R_PROPB) begin
                  prop_base_in = dword_new & PROP_MASK;
               end else if (acc_base8 == R_PENDB) begin
                  pend_base_in = dword_new & PEND_MASK;
               end
            end
         end else begin
            err = 1'b1;
         end
      end else if (acc_size == SIZE_BYTE) begin
         // byte accesses reach the priorities only
         if (in_prio) begin
            rd = {{(DATA_W-8){1'b0}}, prio_ff[prio_widx][prio_bsel +: 8]};
            if (acc_wr) begin
               prio_in[prio_widx][prio_bsel +: 8] = acc_data[7:0];
            end
         end else begin
            err = 1'b1;
         end
      end else if (acc_size != SIZE_WORD || acc_off[1:0] != 2'b00) begin
         err = 1'b1;
      end else if (in_prio) begin
         rd = {{WORD_W{1'b0}}, prio_ff[prio_widx]};
         if (acc_wr) begin
            prio_in[prio_widx] = acc_d32;
         end
      end else if (acc_off == R_CFG0 || acc_off == R_CFG1) begin
         // only the edge bit of each trigger field is held, the low bit reads zero
         for (int k = 0; k < CFG_FIELDS; k++) begin
            rd[2*k+1] = cfg_sel[k];
            if (acc_wr) begin
               if (acc_off[2]) begin
                  edge_bits_in[CFG_FIELDS+k] = acc_d32[2*k+1];
               end else begin
                  edge_bits_in[k] = acc_d32[2*k+1];
               end
            end
         end
      end else begin
         case (acc_off)
            R_CTRL: begin
               rd = {{(DATA_W-1){1'b0}}, lpi_enable_ff};
               // lpi enable only sticks when physical lpis are supported
               if (acc_wr && type_flags_ff[0]) begin
                  lpi_enable_in = acc_d32[0];
               end
            end
            R_WAKER: begin
               rd = {{(DATA_W-3){1'b0}}, wake_ff[1], wake_ff[0], 1'b0};
               // children-asleep follows processor-sleep
               if (acc_wr) begin
                  wake_in = {2{acc_d32[1]}};
               end
            end
            R_PIDR2: begin
               rd = {{(DATA_W-8){1'b0}}, arch_rev_ff, 4'b0000};
            end
            R_GROUP: begin
               rd = DATA_W'(group_bits_ff);
               if (acc_wr) begin
                  group_bits_in = acc_d32;
               end
            end
            R_SETEN: begin
               rd = DATA_W'(enable_bits_ff);
               if (acc_wr) begin
                  enable_bits_in = enable_bits_ff | acc_d32;
               end
            end
            R_CLREN: begin
               rd = DATA_W'(enable_bits_ff);
               if (acc_wr) begin
                  enable_bits_in = enable_bits_ff & ~acc_d32;
               end
            end
            R_SETPD: begin
               rd = DATA_W'(pending_bits_ff);
               if (acc_wr) begin
                  pending_bits_in = pending_bits_ff | acc_d32;
               end
            end
            R_CLRPD: begin
               rd = DATA_W'(pending_bits_ff);
               if (acc_wr) begin
                  pending_bits_in = pending_bits_ff & ~acc_d32;
               end
            end
            R_SETAC: begin
               rd = DATA_W'(active_bits_ff);
               if (acc_wr) begin
                  active_bits_in = active_bits_ff | acc_d32;
               end
            end
            R_CLRAC: begin
               rd = DATA_W'(active_bits_ff);
               if (acc_wr) begin
                  active_bits_in = active_bits_ff & ~acc_d32;
               end
            end
            default: begin
               err = 1'b1;
            end
         endcase
      end
   end

   // response beat: data only for good reads
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_err_in   = out_err_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = (in_cmd_ff == CMD_WRITE || err) ? '0 : rd;
         out_err_in   = err;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         affinity_ff     <= '0;
         type_flags_ff   <= '0;
         arch_rev_ff     <= ARCH_REVISION_RST;
         enable_bits_ff  <= '0;
         pending_bits_ff <= '0;
         active_bits_ff  <= '0;
         group_bits_ff   <= '0;
         edge_bits_ff    <= '0;
         for (int w = 0; w < PRIO_WORDS; w++) begin
            prio_ff[w] <= '0;
         end
         wake_ff         <= 2'b11;
         lpi_enable_ff   <= 1'b0;
         prop_base_ff    <= '0;
         pend_base_ff    <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         affinity_ff     <= affinity_in;
         type_flags_ff   <= type_flags_in;
         arch_rev_ff     <= arch_rev_in;
         enable_bits_ff  <= enable_bits_in;
         pending_bits_ff <= pending_bits_in;
         active_bits_ff  <= active_bits_in;
         group_bits_ff   <= group_bits_in;
         edge_bits_ff    <= edge_bits_in;
         prio_ff         <= prio_in;
         wake_ff         <= wake_in;
         lpi_enable_ff   <= lpi_enable_in;
         prop_base_ff    <= prop_base_in;
         pend_base_ff    <= pend_base_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_cmd_ff   <= in_cmd_in;
      in_pay_ff   <= in_pay_in;
      out_data_ff <= out_data_in;
      out_err_ff  <= out_err_in;
   end

`ifndef NO_ASSERTIONS
   // an error response never carries data
   a_err_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("decode error response with non-zero read data");

   // a held input beat must stay put while the output register is blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_pay_ff) && $stable(in_cmd_ff))
      else $error("input register changed while stalled");

   // the two wake bits always move together
   a_wake_pair: assert property (@(posedge clock) disable iff (reset)
      wake_ff[0] == wake_ff[1])
      else $error("processor-sleep and children-asleep disagree");

   // base registers never hold bits outside their fields
   a_base_masked: assert property (@(posedge clock) disable iff (reset)
      (prop_base_ff & ~PROP_MASK) == '0 && (pend_base_ff & ~PEND_MASK) == '0)
      else $error("lpi table base holds unimplemented bits");

   // lpi enable only turns on when physical lpis are supported
   a_lpi_needs_phys: assert property (@(posedge clock) disable iff (reset)
      $rose(lpi_enable_ff) |-> $past(type_flags_ff[0]))
      else $error("lpi enable set without physical lpi support");
`endif

endmodule

`default_nettype wire
